/* hw/rtl/local_to_utc_date_time_assert.svh */
// ----------------------------------------------------------------------------
// local_to_utc_date_time assertion macros
// clocked concurrent assertion helpers used by local_to_utc_date_time.sv
// ----------------------------------------------------------------------------
`ifndef LOCAL_TO_UTC_DATE_TIME_ASSERT_SVH
`define LOCAL_TO_UTC_DATE_TIME_ASSERT_SVH

// assertion on an explicit clock and reset
`define LTU_ASSERT_ON(clk, rst, label, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion on the block clock and reset
`define LTU_ASSERT(label, prop, msg) \
   `LTU_ASSERT_ON(clock, reset, label, prop, msg)

`endif

/* hw/rtl/ltu_pkg.sv */
// ----------------------------------------------------------------------------
// ltu_pkg
// constants, stage record and month table of the local to utc converter
// ----------------------------------------------------------------------------
`default_nettype none

package ltu_pkg;

   localparam int NUM_STAGES = 15;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 72;

   // pipeline record, fields are filled in as the word moves down
   typedef struct packed {
      logic               err;
      logic [14:0]        yp;       // shifted year, march based
      logic [7:0]         qa;       // yp / 100
      logic [8:0]         doy;      // day of year, march based
      logic signed [12:0] mm;       // local minute of day minus offset
      logic signed [2:0]  kk;       // day carry from the offset
      logic [10:0]        md;       // utc minute of day
      logic [22:0]        y365;
      logic [22:0]        nn;       // day count since shifted origin
      logic [4:0]         hr;
      logic [5:0]         mi;
      logic signed [32:0] tot;      // epoch minutes
      logic [5:0]         era;
      logic [17:0]        doe;      // day of era
      logic [7:0]         qb;       // doe / 1460
      logic [2:0]         cc;       // doe / 36524
      logic               cz;       // doe / 146096
      logic signed [14:0] yb;       // year base
      logic [17:0]        nq;
      logic [9:0]         yoe;      // year of era
      logic [18:0]        yoe365;
      logic [7:0]         yoe4;
      logic [3:0]         yoe100;
      logic [3:0]         mp;       // march based month
      logic signed [14:0] uyear;
      logic [3:0]         umonth;
      logic [4:0]         uday;
   } stage_type;

   // first day of each march based month
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] s;
      case (mp)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd61;
         4'd3:    s = 9'd92;
         4'd4:    s = 9'd122;
         4'd5:    s = 9'd153;
         4'd6:    s = 9'd184;
         4'd7:    s = 9'd214;
         4'd8:    s = 9'd245;
         4'd9:    s = 9'd275;
         4'd10:   s = 9'd306;
         4'd11:   s = 9'd337;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/local_to_utc_date_time.sv */
// ----------------------------------------------------------------------------
// local_to_utc_date_time
// local civil date and time plus zone offset to utc date, time and epoch minutes
// ----------------------------------------------------------------------------
// stage 0 loads at the accept edge, the word leaves the last stage on rsp_tvalid
// throughput: one word per cycle while rsp_tready is high or any stage holds a bubble
// a stall at rsp backs up stage by stage, req stays open while any stage is empty
// reset clears the stage valid bits only, no word is lost or repeated on a stall
`default_nettype none
`include "local_to_utc_date_time_assert.svh"

module local_to_utc_date_time (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // year[13:0] month[17:14] day[22:18] hour[27:23] minute[33:28] tz_offset[45:34]
   input  wire logic [ltu_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // year[14:0] month[18:15] day[23:19] hour[28:24] minute[34:29] epoch_min[67:35]
   output logic [ltu_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // input range error[0], a date or time field out of range
   output logic                                   rsp_tuser
);
   import ltu_pkg::*;

   stage_type              st_ff [NUM_STAGES];
   stage_type              st_in [NUM_STAGES];
   logic [NUM_STAGES-1:0]  vld_ff;
   logic [NUM_STAGES-1:0]  en;

   logic [13:0]        i_year;
   logic [3:0]         i_month;
   logic [4:0]         i_day;
   logic [4:0]         i_hour;
   logic [5:0]         i_minute;
   logic signed [11:0] i_tz;

   logic        mfix;
   logic [14:0] yp0;
   logic [3:0]  mp0;
   logic [23:0] p_q100;
   logic [15:0] r_q100;
   logic [23:0] p_hr;
   logic signed [34:0] tw;
   logic [28:0] p_era;
   logic [23:0] r_era;
   logic [25:0] p_q1460;
   logic [18:0] r_q1460;
   logic [27:0] p_yoe;
   logic [18:0] r_yoe;
   logic [15:0] p_y100;
   logic [18:0] t_doy;
   logic [3:0]  mp_cnt;
   logic [3:0]  mp_l;

   logic        date_ok;
   logic        time_ok;

   assign i_year   = req_tdata[13:0];
   assign i_month  = req_tdata[17:14];
   assign i_day    = req_tdata[22:18];
   assign i_hour   = req_tdata[27:23];
   assign i_minute = req_tdata[33:28];
   assign i_tz     = $signed(req_tdata[45:34]);

   // a stage may load when it or any stage after it holds a bubble, or when rsp_tready is high
   always_comb begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         en[i] = rsp_tready;
         for (int j = i; j < NUM_STAGES; j++) begin
            if (!vld_ff[j]) begin
               en[i] = 1'b1;
            end
         end
      end
   end

   assign req_tready = en[0];

   always_comb begin
      st_in[0] = '0;
      for (int i = 1; i < NUM_STAGES; i++) begin
         st_in[i] = st_ff[i-1];
      end

      // stage 0: range check, march based year and day of year, minute of day
      mfix = i_month inside {[4'd1:4'd2]};
      yp0  = 15'(i_year) + 15'd400 - 15'(mfix);
      mp0  = (i_month > 4'd2) ? (i_month - 4'd3) : (i_month + 4'd9);
      p_q100 = 24'(yp0) * 24'd327;
      st_in[0].err = (i_year > 14'd9999) || (i_month == 4'd0) || (i_month > 4'd12) ||
                     (i_day == 5'd0) || (i_hour > 5'd23) || (i_minute > 6'd59);
      st_in[0].yp  = yp0;
      st_in[0].qa  = p_q100[22:15];
      st_in[0].doy = month_start(mp0) + 9'(i_day) - 9'd1;
      st_in[0].mm  = $signed({8'b0, i_hour}) * 13'sd60 + $signed({7'b0, i_minute})
                     - 13'(i_tz);

      // stage 1: fix yp / 100, yp times 365, split off the day carry
      r_q100 = 16'(st_ff[0].yp) - 16'(st_ff[0].qa) * 16'd100;
      if (r_q100 >= 16'd100) begin
         st_in[1].qa = st_ff[0].qa + 8'd1;
      end
      st_in[1].y365 = 23'(st_ff[0].yp) * 23'd365;
      if (st_ff[0].mm < -13'sd1440) begin
         st_in[1].kk = -3'sd2;
         st_in[1].md = 11'(st_ff[0].mm + 13'sd2880);
      end else if (st_ff[0].mm < 13'sd0) begin
         st_in[1].kk = -3'sd1;
         st_in[1].md = 11'(st_ff[0].mm + 13'sd1440);
      end else if (st_ff[0].mm < 13'sd1440) begin
         st_in[1].kk = 3'sd0;
         st_in[1].md = 11'(st_ff[0].mm);
      end else if (st_ff[0].mm < 13'sd2880) begin
         st_in[1].kk = 3'sd1;
         st_in[1].md = 11'(st_ff[0].mm - 13'sd1440);
      end else begin
         st_in[1].kk = 3'sd2;
         st_in[1].md = 11'(st_ff[0].mm - 13'sd2880);
      end

      // stage 2: local day count, utc hour
      st_in[2].nn = st_ff[1].y365 + 23'(st_ff[1].yp >> 2) - 23'(st_ff[1].qa)
                    + 23'(st_ff[1].qa >> 2) + 23'(st_ff[1].doy);
      p_hr = 24'(st_ff[1].md) * 24'd2185;
      st_in[2].hr = p_hr[21:17];

      // stage 3: epoch minutes, utc day count, utc minute
      tw = $signed({12'b0, st_ff[2].nn}) * 35'sd1440 - 35'sd1246413600
           + 35'(st_ff[2].mm);
      st_in[3].tot = tw[32:0];
      st_in[3].nn  = st_ff[2].nn + {{20{st_ff[2].kk[2]}}, st_ff[2].kk};
      st_in[3].mi  = 6'(st_ff[2].md - 11'(st_ff[2].hr) * 11'd60);

      // stage 4: era estimate
      p_era = 29'(st_ff[3].nn) * 29'd57;
      st_in[4].era = p_era[28:23];

      // stage 5: fix era, day of era
      r_era = 24'(st_ff[4].nn) - 24'(st_ff[4].era) * 24'd146097;
      if (r_era >= 24'd146097) begin
         st_in[5].era = st_ff[4].era + 6'd1;
         st_in[5].doe = 18'(r_era - 24'd146097);
      end else begin
         st_in[5].doe = r_era[17:0];
      end

      // stage 6: leap day terms of the era, year base
      p_q1460 = 26'(st_ff[5].doe) * 26'd179;
      st_in[6].qb = p_q1460[25:18];
      st_in[6].cc = 3'(st_ff[5].doe >= 18'd36524) + 3'(st_ff[5].doe >= 18'd73048)
                    + 3'(st_ff[5].doe >= 18'd109572) + 3'(st_ff[5].doe >= 18'd146096);
      st_in[6].cz = (st_ff[5].doe >= 18'd146096);
      st_in[6].yb = $signed(15'(st_ff[5].era) * 15'd400) - 15'sd400;

      // stage 7: fix doe / 1460
      r_q1460 = 19'(st_ff[6].doe) - 19'(st_ff[6].qb) * 19'd1460;
      if (r_q1460 >= 19'd1460) begin
         st_in[7].qb = st_ff[6].qb + 8'd1;
      end

      // stage 8
      st_in[8].nq = 18'(19'(st_ff[7].doe) - 19'(st_ff[7].qb) + 19'(st_ff[7].cc)
                        - 19'(st_ff[7].cz));

      // stage 9: year of era estimate
      p_yoe = 28'(st_ff[8].nq) * 28'd718;
      st_in[9].yoe = p_yoe[27:18];

      // stage 10: fix year of era
      r_yoe = 19'(st_ff[9].nq) - 19'(st_ff[9].yoe) * 19'd365;
      if (r_yoe >= 19'd365) begin
         st_in[10].yoe = st_ff[9].yoe + 10'd1;
      end

      // stage 11: days before this year of era, year base plus year of era
      st_in[11].yoe365 = 19'(st_ff[10].yoe) * 19'd365;
      st_in[11].yoe4   = st_ff[10].yoe[9:2];
      p_y100 = 16'(st_ff[10].yoe) * 16'd41;
      st_in[11].yoe100 = p_y100[15:12];
      st_in[11].yb = st_ff[10].yb + $signed({5'b0, st_ff[10].yoe});

      // stage 12: utc day of year
      t_doy = 19'(st_ff[11].doe) - (st_ff[11].yoe365 + 19'(st_ff[11].yoe4)
                                    - 19'(st_ff[11].yoe100));
      st_in[12].doy = t_doy[8:0];

      // stage 13: month lookup by threshold count
      mp_cnt = 4'd0;
      for (int j = 1; j < 12; j++) begin
         if (st_ff[12].doy >= month_start(4'(j))) begin
            mp_cnt = mp_cnt + 4'd1;
         end
      end
      st_in[13].mp = mp_cnt;

      // stage 14: civil fields, rejected words read as zero
      mp_l = st_ff[13].mp;
      st_in[14].uday   = 5'(st_ff[13].doy - month_start(mp_l) + 9'd1);
      st_in[14].umonth = (mp_l < 4'd10) ? (mp_l + 4'd3) : (mp_l - 4'd9);
      st_in[14].uyear  = st_ff[13].yb + $signed({14'b0, (mp_l >= 4'd10)});
      if (st_ff[13].err) begin
         st_in[14].uday   = '0;
         st_in[14].umonth = '0;
         st_in[14].uyear  = '0;
         st_in[14].hr     = '0;
         st_in[14].mi     = '0;
         st_in[14].tot    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         if (en[i]) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign rsp_tvalid = vld_ff[NUM_STAGES-1];
   assign rsp_tdata  = {4'b0,
                        st_ff[NUM_STAGES-1].tot,
                        st_ff[NUM_STAGES-1].mi,
                        st_ff[NUM_STAGES-1].hr,
                        st_ff[NUM_STAGES-1].uday,
                        st_ff[NUM_STAGES-1].umonth,
                        st_ff[NUM_STAGES-1].uyear};
   assign rsp_tuser  = st_ff[NUM_STAGES-1].err;

   assign date_ok = (st_ff[NUM_STAGES-1].umonth inside {[4'd1:4'd12]}) &&
                    (st_ff[NUM_STAGES-1].uday != 5'd0);
   assign time_ok = (st_ff[NUM_STAGES-1].hr <= 5'd23) && (st_ff[NUM_STAGES-1].mi <= 6'd59);

   // a bubble anywhere in the pipe must keep the input open
   `LTU_ASSERT(a_bubble_ready, (!(&vld_ff)) |-> req_tready, "req stalled with a bubble")
   // rejected words carry all zero fields
   `LTU_ASSERT(a_err_zero, (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0), "rejected word not zero")
   // accepted words give a proper civil date and time
   `LTU_ASSERT(a_civil_date, (rsp_tvalid && !rsp_tuser) |-> date_ok, "utc date out of range")
   `LTU_ASSERT(a_civil_time, (rsp_tvalid && !rsp_tuser) |-> time_ok, "utc time out of range")

endmodule

`default_nettype wire
